@@ design/pore_candidate_range_classifier_macros.svh @@
// Assertion macros shared by the pore candidate classifier modules.
`ifndef PORE_CANDIDATE_RANGE_CLASSIFIER_MACROS_SVH
`define PORE_CANDIDATE_RANGE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCRC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCRC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pcrc_pkg.sv @@
// Types, constants and helper functions of the pore candidate classifier.
package pcrc_pkg;

  // Stream and configuration widths.
  localparam int unsigned InDataW  = 272;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Group bookkeeping.
  localparam int unsigned MaxCandidates = 1024;
  localparam int unsigned CountW        = 11;
  localparam logic [CountW-1:0] CountCap =
    (MaxCandidates > ((1 << CountW) - 1)) ? CountW'((1 << CountW) - 1)
                                          : CountW'(MaxCandidates);

  // Q16.16 constants.
  localparam logic signed [31:0] MinusOneQ16 = 32'shFFFF_0000;
  localparam logic signed [31:0] Int32Max    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Int32Min    = 32'sh8000_0000;

  // Range register indexes.
  localparam logic [CfgIdxW-1:0] RegArea     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRatio    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegContrast = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTexture  = 3'd5;
  localparam int unsigned        NumRanges   = 6;

  // Features of the candidate under work, held for the range tests.
  // The first member sits in the highest bits, so the layout follows the input stream.
  typedef struct packed {
    logic [39:0]        feature_ranks;
    logic signed [31:0] texture;
    logic signed [31:0] contrast;
    logic signed [31:0] axis_ratio;
    logic signed [31:0] height_mm;
    logic signed [31:0] width_mm;
  } feat_t;

  // Hand-over of a finished candidate to the accumulator.
  typedef struct packed {
    logic valid;
    logic last;
  } step_t;

  // Inclusive signed test against a packed low/high range register.
  function automatic logic in_range(logic [63:0] rng, logic signed [31:0] v);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = $signed(rng[31:0]);
    hi = $signed(rng[63:32]);
    return (lo <= v) && (v <= hi);
  endfunction

endpackage

@@ design/pcrc_mul.sv @@
// Shared signed multiplier with a registered product.
module pcrc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);

  logic signed [65:0] prod_q;

  // One product per cycle, available on the following cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

@@ design/pcrc_div.sv @@
// Radix-2 restoring divider giving a 32-bit quotient, one bit per cycle.
module pcrc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] rem_i,
  input  logic [31:0] num_i,
  input  logic [39:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [39:0] rem_q, rem_d;
  logic [31:0] quot_q, quot_d;
  logic [39:0] den_q, den_d;
  logic [40:0] shifted;
  logic        fits;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    shifted = {rem_q, quot_q[31]};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = rem_i;
      quot_d = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = fits ? 40'(shifted - {1'b0, den_q}) : shifted[39:0];
      quot_d = {quot_q[30:0], fits};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/pcrc_acc.sv @@
// Range tests, per-group pore statistics and the result register.
`include "pore_candidate_range_classifier_macros.svh"

module pcrc_acc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcrc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pcrc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  pcrc_pkg::step_t                  step_i,
  input  logic signed [31:0]               area_i,
  input  pcrc_pkg::feat_t                  feat_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [pcrc_pkg::CountW-1:0]      res_count_o,
  output logic signed [31:0]               res_largest_o,
  output logic signed [31:0]               res_smallest_o,
  output logic                             res_reject_o
);

  logic [pcrc_pkg::CfgDataW-1:0] cfg_q [pcrc_pkg::NumRanges];

  logic [pcrc_pkg::CountW-1:0] count_q, count_d;
  logic signed [31:0]          max_q, max_d;
  logic signed [31:0]          min_q, min_d;
  logic                        out_valid_q, out_valid_d;
  logic [pcrc_pkg::CountW-1:0] out_count_q, out_count_d;
  logic signed [31:0]          out_max_q, out_max_d;
  logic signed [31:0]          out_min_q, out_min_d;

  logic                        ranks_ok;
  logic                        pore;
  logic [pcrc_pkg::CountW-1:0] cnt_n;
  logic signed [31:0]          max_n;
  logic signed [31:0]          min_n;

  // Range registers, to be written only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pcrc_pkg::NumRanges; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (32'(cfg_idx_i) < pcrc_pkg::NumRanges)) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // A candidate is a pore when every range test passes and no rank is zero.
  always_comb begin
    ranks_ok = 1'b1;
    for (int i = 0; i < 5; i++) begin
      if (feat_i.feature_ranks[8*i +: 8] == 8'd0) begin
        ranks_ok = 1'b0;
      end
    end
    pore = ranks_ok
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegArea], area_i)
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegWidth], feat_i.width_mm)
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegHeight], feat_i.height_mm)
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegRatio], feat_i.axis_ratio)
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegContrast], feat_i.contrast)
        && pcrc_pkg::in_range(cfg_q[pcrc_pkg::RegTexture], feat_i.texture);
  end

  // Statistics after this candidate; the first pore sets both extremes.
  always_comb begin
    cnt_n = count_q;
    max_n = max_q;
    min_n = min_q;
    if (pore) begin
      if (count_q == '0) begin
        max_n = area_i;
        min_n = area_i;
      end else begin
        if (area_i > max_q) max_n = area_i;
        if (area_i < min_q) min_n = area_i;
      end
      if (count_q < pcrc_pkg::CountCap) cnt_n = count_q + 1'b1;
    end
  end

  // Group state and the result register.
  always_comb begin
    count_d     = count_q;
    max_d       = max_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_count_d = out_count_q;
    out_max_d   = out_max_q;
    out_min_d   = out_min_q;
    if (step_i.valid) begin
      if (step_i.last) begin
        out_valid_d = 1'b1;
        out_count_d = cnt_n;
        out_max_d   = (cnt_n != '0) ? max_n : pcrc_pkg::MinusOneQ16;
        out_min_d   = (cnt_n != '0) ? min_n : pcrc_pkg::MinusOneQ16;
        count_d     = '0;
        max_d       = pcrc_pkg::MinusOneQ16;
        min_d       = pcrc_pkg::MinusOneQ16;
      end else begin
        count_d = cnt_n;
        max_d   = max_n;
        min_d   = min_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      max_q       <= pcrc_pkg::MinusOneQ16;
      min_q       <= pcrc_pkg::MinusOneQ16;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      max_q       <= max_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
    out_max_q   <= out_max_d;
    out_min_q   <= out_min_d;
  end

  assign res_valid_o    = out_valid_q;
  assign res_count_o    = out_count_q;
  assign res_largest_o  = out_max_q;
  assign res_smallest_o = out_min_q;
  assign res_reject_o   = out_count_q != '0;

  // The pore count never passes its cap.
  `PCRC_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= pcrc_pkg::CountCap, "pore count above cap")
  // With no pore recorded, both extremes hold minus one.
  `PCRC_ASSERT_IMP(a_empty_extremes, clk_i, rst_ni, count_q == '0, (max_q == pcrc_pkg::MinusOneQ16) && (min_q == pcrc_pkg::MinusOneQ16), "extremes set without a pore")

endmodule

@@ design/pore_candidate_range_classifier.sv @@
// Sequence: states MBOX, MWH, MABS, MLO, MHI, MSUM and DCHK, then DIV and RES when the area needs
// the divider, then FIN; DCHK goes straight to FIN for an empty box or an early saturated area.
// A new candidate is taken only in IDLE; the 32-step divider makes the long path,
// and a full result register not yet taken holds the final step of a group's last item.
// Reset (rst_ni low, asynchronous): sequencer idle, range registers zero, count zero,
// largest and smallest area minus one, no result pending.
`include "pore_candidate_range_classifier_macros.svh"

module pore_candidate_range_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: box_x_min, box_x_max, box_y_min, box_y_max, blob_pixels, width_mm,
  // height_mm, axis_ratio, contrast, texture, feature_ranks.
  input  logic [pcrc_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: pore_count, largest_area, smallest_area, reject, zero padding.
  output logic [pcrc_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [pcrc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pcrc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // Sequencer codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MBOX = 4'd1;
  localparam logic [3:0] ST_MWH  = 4'd2;
  localparam logic [3:0] ST_MABS = 4'd3;
  localparam logic [3:0] ST_MLO  = 4'd4;
  localparam logic [3:0] ST_MHI  = 4'd5;
  localparam logic [3:0] ST_MSUM = 4'd6;
  localparam logic [3:0] ST_DCHK = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_RES  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0] state_q, state_d;

  logic signed [12:0] bw_q, bh_q;
  logic [23:0]        pix_q;
  pcrc_pkg::feat_t    feat_q;
  logic               last_q;
  logic               box_neg_q, box_zero_q;
  logic [23:0]        box_abs_q;
  logic               wh_neg_q;
  logic [62:0]        p_q;
  logic [55:0]        a_q;
  logic [85:0]        n_q;
  logic signed [31:0] area_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [24:0] box;
  logic signed [63:0] wh;
  logic [39:0]        den;
  logic               big;
  logic               neg;
  logic               accept;
  logic               fin_go;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;
  pcrc_pkg::step_t    step;

  logic [pcrc_pkg::CountW-1:0] res_count;
  logic signed [31:0]          res_largest, res_smallest;
  logic                        res_reject;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;

  assign box = prod[24:0];
  assign wh  = prod[63:0];
  assign den = {box_abs_q, 16'd0};
  assign big = n_q[85:32] >= {14'd0, den};
  assign neg = wh_neg_q ^ box_neg_q;

  // A group's last candidate waits until the result register is free.
  assign fin_go     = !last_q || !m_axis_tvalid || m_axis_tready;
  assign step.valid = (state_q == ST_FIN) && fin_go;
  assign step.last  = last_q;

  assign div_start = (state_q == ST_DCHK) && !box_zero_q && !big;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MBOX: begin
        mul_a = 33'(bw_q);
        mul_b = 33'(bh_q);
      end
      ST_MWH: begin
        mul_a = 33'(feat_q.width_mm);
        mul_b = 33'(feat_q.height_mm);
      end
      ST_MLO: begin
        mul_a = $signed({1'b0, p_q[31:0]});
        mul_b = $signed({9'd0, pix_q});
      end
      ST_MHI: begin
        mul_a = $signed({2'd0, p_q[62:32]});
        mul_b = $signed({9'd0, pix_q});
      end
      default: begin
      end
    endcase
  end

  pcrc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pcrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (n_q[71:32]),
    .num_i   (n_q[31:0]),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Next sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_MBOX;
      ST_MBOX: state_d = ST_MWH;
      ST_MWH:  state_d = ST_MABS;
      ST_MABS: state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_MSUM;
      ST_MSUM: state_d = ST_DCHK;
      ST_DCHK: state_d = (box_zero_q || big) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_RES;
      ST_RES:  state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Candidate capture and the area datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bw_q   <= $signed({1'b0, s_axis_tdata[23:12]}) - $signed({1'b0, s_axis_tdata[11:0]});
      bh_q   <= $signed({1'b0, s_axis_tdata[47:36]}) - $signed({1'b0, s_axis_tdata[35:24]});
      pix_q  <= s_axis_tdata[71:48];
      feat_q <= s_axis_tdata[271:72];
      last_q <= s_axis_tlast;
    end
    unique case (state_q)
      ST_MWH: begin
        box_neg_q  <= box[24];
        box_zero_q <= box == '0;
        box_abs_q  <= box[24] ? 24'(-box) : box[23:0];
      end
      ST_MABS: begin
        wh_neg_q <= wh[63];
        p_q      <= wh[63] ? 63'(-wh) : wh[62:0];
      end
      ST_MHI: begin
        a_q <= prod[55:0];
      end
      ST_MSUM: begin
        n_q <= {30'd0, a_q} + {prod[53:0], 32'd0};
      end
      ST_DCHK: begin
        // Empty box follows the sign of the mm product; an oversized quotient saturates.
        if (box_zero_q) begin
          area_q <= wh_neg_q ? pcrc_pkg::Int32Min : pcrc_pkg::Int32Max;
        end else begin
          area_q <= neg ? pcrc_pkg::Int32Min : pcrc_pkg::Int32Max;
        end
      end
      ST_RES: begin
        if (neg) begin
          area_q <= div_quot[31] ? pcrc_pkg::Int32Min : $signed(~div_quot + 32'd1);
        end else begin
          area_q <= div_quot[31] ? pcrc_pkg::Int32Max : $signed(div_quot);
        end
      end
      default: begin
      end
    endcase
  end

  pcrc_acc u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .step_i         (step),
    .area_i         (area_q),
    .feat_i         (feat_q),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_count_o    (res_count),
    .res_largest_o  (res_largest),
    .res_smallest_o (res_smallest),
    .res_reject_o   (res_reject)
  );

  assign m_axis_tdata = {4'd0, res_reject, res_smallest, res_largest, res_count};

  // The divider only finishes while the sequencer waits on it.
  `PCRC_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_done, state_q == ST_DIV, "divider done outside its wait state")
  // A group's final step never overwrites a result still waiting for transfer.
  `PCRC_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, step.valid && step.last, !m_axis_tvalid || m_axis_tready, "result overwritten")
  // An accepted candidate starts at the box multiply.
  `PCRC_ASSERT_NEXT(a_accept_start, clk_i, rst_ni, accept, state_q == ST_MBOX, "sequencer did not start")

endmodule
